// File: design/elc_pkg.sv
// Shared types, codes and reset constants for the elevator car LOOK controller.
// Used by every module of the design; depends on nothing.
package elc_pkg;

  localparam int NUM_FLOORS_DEF = 32;

  localparam int FLOOR_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_UP    = 6'b000010,
    PH_DOWN  = 6'b000100,
    PH_OPEN  = 6'b001000,
    PH_BOARD = 6'b010000,
    PH_CLOSE = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_HALL  = 2'd1,
    MODE_BOARD = 2'd2,
    MODE_EXIT  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_BOARDING = 3'd1,
    ST_FULL         = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_UNSERVED     = 3'd4
  } status_t;

  localparam logic [2:0] CS_IDLE  = 3'd0;
  localparam logic [2:0] CS_UP    = 3'd1;
  localparam logic [2:0] CS_DOWN  = 3'd2;
  localparam logic [2:0] CS_OPEN  = 3'd3;
  localparam logic [2:0] CS_BOARD = 3'd4;
  localparam logic [2:0] CS_CLOSE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd4;

  typedef struct packed {
    logic [4:0] bottom;
    logic [4:0] top;
    logic [7:0] hold;
    logic [2:0] speed;
    logic [5:0] capacity;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{bottom: 5'd0, top: 5'd31, hold: 8'd3,
                                 speed: 3'd1, capacity: 6'd8};

  typedef struct packed {
    logic [1:0]         mode;
    logic [FLOOR_W-1:0] floor;
    logic [1:0]         call_dir;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               arrived;
    logic [FLOOR_W-1:0] floor_now;
    logic [2:0]         car_state;
    logic [1:0]         travel_dir;
    logic [5:0]         riders;
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:  code = CS_IDLE;
      PH_UP:    code = CS_UP;
      PH_DOWN:  code = CS_DOWN;
      PH_OPEN:  code = CS_OPEN;
      PH_BOARD: code = CS_BOARD;
      PH_CLOSE: code = CS_CLOSE;
      default:  code = CS_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: design/elc_range.sv
// Served floor range: effective lowest and highest floor and the per-floor mask.
// Depends on elc_pkg.
module elc_range #(
  parameter int NUM_FLOORS = elc_pkg::NUM_FLOORS_DEF
) (
  input  logic [elc_pkg::FLOOR_W-1:0] bottom,
  input  logic [elc_pkg::FLOOR_W-1:0] top,
  output logic [elc_pkg::FLOOR_W-1:0] lo,
  output logic [elc_pkg::FLOOR_W-1:0] hi,
  output logic [NUM_FLOORS-1:0]       mask
);
  import elc_pkg::*;

  localparam logic [FLOOR_W:0] LAST = (FLOOR_W + 1)'(NUM_FLOORS - 1);

  logic [FLOOR_W-1:0] top_cl;

  always_comb begin
    lo     = ({1'b0, bottom} > LAST) ? LAST[FLOOR_W-1:0] : bottom;
    top_cl = ({1'b0, top} > LAST) ? LAST[FLOOR_W-1:0] : top;
    hi     = (top_cl < lo) ? lo : top_cl;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      mask[i] = ((FLOOR_W + 1)'(i) >= {1'b0, lo}) && ((FLOOR_W + 1)'(i) <= {1'b0, hi});
    end
  end

endmodule

// File: design/elc_look.sv
// LOOK target choice over the pending call bitmap with two priority encoders.
// Depends on elc_pkg.
module elc_look #(
  parameter int NUM_FLOORS = elc_pkg::NUM_FLOORS_DEF
) (
  input  logic [NUM_FLOORS-1:0]       calls,
  input  logic [elc_pkg::FLOOR_W-1:0] pos,
  input  elc_pkg::dir_t               heading,
  output logic                        found,
  output logic [elc_pkg::FLOOR_W-1:0] next
);
  import elc_pkg::*;

  logic [NUM_FLOORS-1:0] below;
  logic [NUM_FLOORS-1:0] above;
  logic [FLOOR_W:0]      near_above;
  logic [FLOOR_W:0]      near_below;
  logic [FLOOR_W:0]      dist_above;
  logic [FLOOR_W:0]      dist_below;
  logic                  has_above;
  logic                  has_below;

  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      below[i] = calls[i] && ((FLOOR_W + 1)'(i) < {1'b0, pos});
      above[i] = calls[i] && ((FLOOR_W + 1)'(i) > {1'b0, pos});
    end
    near_above = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (above[i]) begin
        near_above = (FLOOR_W + 1)'(i);
      end
    end
    near_below = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (below[i]) begin
        near_below = (FLOOR_W + 1)'(i);
      end
    end
    has_above  = |above;
    has_below  = |below;
    dist_above = near_above - {1'b0, pos};
    dist_below = {1'b0, pos} - near_below;
    found      = has_above || has_below;

    if (heading == DIR_UP && has_above) begin
      next = near_above[FLOOR_W-1:0];
    end else if (heading == DIR_DOWN && has_below) begin
      next = near_below[FLOOR_W-1:0];
    end else if (has_below && (!has_above || dist_below <= dist_above)) begin
      next = near_below[FLOOR_W-1:0];
    end else begin
      next = near_above[FLOOR_W-1:0];
    end
  end

endmodule

// File: design/elc_core.sv
// Car state, call bitmaps and configuration registers with the per-item update.
// Depends on elc_pkg, elc_range and elc_look.
module elc_core #(
  parameter int NUM_FLOORS = elc_pkg::NUM_FLOORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [elc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [elc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          step,
  input  elc_pkg::item_t                item,
  output elc_pkg::result_t              res
);
  import elc_pkg::*;

  cfg_t                  cfg_r, cfg_nxt;
  logic [NUM_FLOORS-1:0] car_r, car_nxt;
  logic [NUM_FLOORS-1:0] hidle_r, hidle_nxt;
  logic [NUM_FLOORS-1:0] hup_r, hup_nxt;
  logic [NUM_FLOORS-1:0] hdown_r, hdown_nxt;
  logic [FLOOR_W-1:0]    pos_r, pos_nxt;
  logic [FLOOR_W-1:0]    goal_r, goal_nxt;
  logic                  gset_r, gset_nxt;
  phase_t                phase_r, phase_nxt;
  dir_t                  head_r, head_nxt;
  logic [7:0]            door_r, door_nxt;
  logic [5:0]            riders_r, riders_nxt;

  logic [FLOOR_W-1:0]    lo, hi, new_lo, new_hi;
  logic [NUM_FLOORS-1:0] range_mask, new_mask;
  logic [NUM_FLOORS-1:0] pos_oh, fl_oh, np_oh, hall_any, calls;
  logic                  look_found;
  logic [FLOOR_W-1:0]    look_next;
  logic                  here_hall, hall_stop, in_range, range_wr;
  logic [2:0]            speed;
  logic [FLOOR_W:0]      up_t, lo_sp;
  logic [FLOOR_W-1:0]    dn_t, np;
  logic [7:0]            door_dec;
  status_t               status;
  logic                  arrived;

  elc_range #(.NUM_FLOORS(NUM_FLOORS)) u_range_cur (
    .bottom(cfg_r.bottom), .top(cfg_r.top), .lo(lo), .hi(hi), .mask(range_mask)
  );

  elc_range #(.NUM_FLOORS(NUM_FLOORS)) u_range_new (
    .bottom(cfg_nxt.bottom), .top(cfg_nxt.top), .lo(new_lo), .hi(new_hi), .mask(new_mask)
  );

  assign hall_any = hidle_r | hup_r | hdown_r;
  assign calls    = (car_r | hall_any) & range_mask;

  elc_look #(.NUM_FLOORS(NUM_FLOORS)) u_look (
    .calls(calls), .pos(pos_r), .heading(head_r), .found(look_found), .next(look_next)
  );

  always_comb begin
    cfg_nxt  = cfg_r;
    range_wr = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BOTTOM: begin
          cfg_nxt.bottom = cfg_data[4:0];
          range_wr       = 1'b1;
        end
        CFG_TOP: begin
          cfg_nxt.top = cfg_data[4:0];
          range_wr    = 1'b1;
        end
        CFG_HOLD:     cfg_nxt.hold     = cfg_data;
        CFG_SPEED:    cfg_nxt.speed    = cfg_data[2:0];
        CFG_CAPACITY: cfg_nxt.capacity = cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    speed = (cfg_r.speed == 3'd0) ? 3'd1 : cfg_r.speed;

    up_t = {1'b0, pos_r} + {3'b000, speed};
    if (gset_r && goal_r > pos_r && up_t > {1'b0, goal_r}) begin
      up_t = {1'b0, goal_r};
    end
    if (up_t > {1'b0, hi}) begin
      up_t = {1'b0, hi};
    end

    lo_sp = {1'b0, lo} + {3'b000, speed};
    dn_t  = ({1'b0, pos_r} < lo_sp) ? lo : pos_r - {2'b00, speed};
    if (gset_r && goal_r < pos_r && dn_t < goal_r) begin
      dn_t = goal_r;
    end

    np = (phase_r == PH_UP) ? up_t[FLOOR_W-1:0] : dn_t;

    for (int i = 0; i < NUM_FLOORS; i++) begin
      pos_oh[i] = ({1'b0, pos_r} == (FLOOR_W + 1)'(i));
      fl_oh[i]  = ({1'b0, item.floor} == (FLOOR_W + 1)'(i));
      np_oh[i]  = ({1'b0, np} == (FLOOR_W + 1)'(i));
    end

    here_hall = |(hall_any & pos_oh);
    hall_stop = (|(hidle_r & np_oh)) ||
                (head_r == DIR_UP && (|(hup_r & np_oh))) ||
                (head_r == DIR_DOWN && (|(hdown_r & np_oh)));
    in_range  = (item.floor >= lo) && (item.floor <= hi);
    door_dec  = (door_r == 8'd0) ? 8'd0 : door_r - 8'd1;
  end

  always_comb begin
    car_nxt    = car_r;
    hidle_nxt  = hidle_r;
    hup_nxt    = hup_r;
    hdown_nxt  = hdown_r;
    pos_nxt    = pos_r;
    goal_nxt   = goal_r;
    gset_nxt   = gset_r;
    phase_nxt  = phase_r;
    head_nxt   = head_r;
    door_nxt   = door_r;
    riders_nxt = riders_r;
    status     = ST_OK;
    arrived    = 1'b0;

    if (range_wr) begin
      if (pos_r < new_lo) begin
        pos_nxt = new_lo;
      end else if (pos_r > new_hi) begin
        pos_nxt = new_hi;
      end
      if (gset_r) begin
        if (goal_r < new_lo) begin
          goal_nxt = new_lo;
        end else if (goal_r > new_hi) begin
          goal_nxt = new_hi;
        end
      end
      car_nxt   = car_r & new_mask;
      hidle_nxt = hidle_r & new_mask;
      hup_nxt   = hup_r & new_mask;
      hdown_nxt = hdown_r & new_mask;
    end else if (step) begin
      case (mode_t'(item.mode))
        MODE_TICK: begin
          case (phase_r)
            PH_IDLE, PH_CLOSE: begin
              if (here_hall) begin
                phase_nxt = PH_OPEN;
                door_nxt  = cfg_r.hold;
              end else if (look_found) begin
                goal_nxt = look_next;
                gset_nxt = 1'b1;
                if (look_next > pos_r) begin
                  phase_nxt = PH_UP;
                  head_nxt  = DIR_UP;
                end else begin
                  phase_nxt = PH_DOWN;
                  head_nxt  = DIR_DOWN;
                end
              end else if (phase_r == PH_CLOSE) begin
                phase_nxt = PH_IDLE;
                head_nxt  = DIR_IDLE;
                gset_nxt  = 1'b0;
                goal_nxt  = '0;
              end
            end
            PH_UP, PH_DOWN: begin
              pos_nxt = np;
              if ((gset_r && np == goal_r) || np == pos_r || hall_stop) begin
                goal_nxt  = np;
                gset_nxt  = 1'b1;
                phase_nxt = PH_OPEN;
                door_nxt  = cfg_r.hold;
                arrived   = 1'b1;
              end
            end
            PH_OPEN: phase_nxt = PH_BOARD;
            PH_BOARD: begin
              door_nxt = door_dec;
              if (door_dec == 8'd0) begin
                car_nxt   = car_r & ~pos_oh;
                hidle_nxt = hidle_r & ~pos_oh;
                hup_nxt   = hup_r & ~pos_oh;
                hdown_nxt = hdown_r & ~pos_oh;
                phase_nxt = PH_CLOSE;
              end
            end
            default: ;
          endcase
        end
        MODE_HALL: begin
          if (!in_range) begin
            status = ST_UNSERVED;
          end else if (item.call_dir == DIR_UP) begin
            hup_nxt = hup_r | fl_oh;
          end else if (item.call_dir == DIR_DOWN) begin
            hdown_nxt = hdown_r | fl_oh;
          end else begin
            hidle_nxt = hidle_r | fl_oh;
          end
        end
        MODE_BOARD: begin
          if (phase_r != PH_BOARD) begin
            status = ST_NOT_BOARDING;
          end else if (riders_r >= cfg_r.capacity) begin
            status = ST_FULL;
          end else if (!in_range) begin
            status = ST_OUT_OF_RANGE;
          end else begin
            riders_nxt = riders_r + 6'd1;
            car_nxt    = car_r | fl_oh;
          end
        end
        MODE_EXIT: begin
          if (riders_r != 6'd0) begin
            riders_nxt = riders_r - 6'd1;
          end
        end
        default: ;
      endcase
    end

    res.status       = status;
    res.arrived      = arrived;
    res.floor_now    = pos_nxt;
    res.car_state    = phase_code(phase_nxt);
    res.travel_dir   = head_nxt;
    res.riders       = riders_nxt;
    res.target_valid = gset_nxt;
    res.target_floor = goal_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= CFG_RESET;
      car_r    <= '0;
      hidle_r  <= '0;
      hup_r    <= '0;
      hdown_r  <= '0;
      pos_r    <= CFG_RESET.bottom;
      goal_r   <= '0;
      gset_r   <= 1'b0;
      phase_r  <= PH_IDLE;
      head_r   <= DIR_IDLE;
      door_r   <= '0;
      riders_r <= '0;
    end else begin
      cfg_r    <= cfg_nxt;
      car_r    <= car_nxt;
      hidle_r  <= hidle_nxt;
      hup_r    <= hup_nxt;
      hdown_r  <= hdown_nxt;
      pos_r    <= pos_nxt;
      goal_r   <= goal_nxt;
      gset_r   <= gset_nxt;
      phase_r  <= phase_nxt;
      head_r   <= head_nxt;
      door_r   <= door_nxt;
      riders_r <= riders_nxt;
    end
  end

endmodule

// File: design/elevator_car_look_controller.sv
// Top level of the elevator car LOOK controller: input register, core, result register.
// Depends on elc_pkg and elc_core.
//
//   channel | ports                                      | direction
//   input   | in_valid, in_stall, in_mode/floor/call_dir | item in
//   result  | out_valid, out_stall, out_status ... target | result out
//   config  | cfg_we, cfg_index, cfg_data                | register write
//
// Each item waits in the input register and is applied to the car state
// as it moves into the result register.
// One item is taken per cycle while the result side keeps up.
// A stalled result holds the result register, and an item waiting in the input
// register then raises in_stall.
// Reset is synchronous; it clears the car state, call bitmaps and valid flags and loads CFG_RESET.
module elevator_car_look_controller #(
  parameter int NUM_FLOORS = elc_pkg::NUM_FLOORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [elc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [elc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [elc_pkg::FLOOR_W-1:0]    in_floor,
  input  logic [1:0]                     in_call_dir,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic                           out_arrived,
  output logic [elc_pkg::FLOOR_W-1:0]    out_floor_now,
  output logic [2:0]                     out_car_state,
  output logic [1:0]                     out_travel_dir,
  output logic [5:0]                     out_riders,
  output logic                           out_target_valid,
  output logic [elc_pkg::FLOOR_W-1:0]    out_target_floor
);
  import elc_pkg::*;

  item_t   item_r, item_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t core_res;
  logic    advance;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  elc_core #(.NUM_FLOORS(NUM_FLOORS)) u_core (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .step(advance), .item(item_r), .res(core_res)
  );

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    item_nxt     = item_r;
    if (in_valid && !in_stall) begin
      item_nxt = '{mode: in_mode, floor: in_floor, call_dir: in_call_dir};
    end
    res_nxt       = advance ? core_res : res_r;
    out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_arrived      = res_r.arrived;
  assign out_floor_now    = res_r.floor_now;
  assign out_car_state    = res_r.car_state;
  assign out_travel_dir   = res_r.travel_dir;
  assign out_riders       = res_r.riders;
  assign out_target_valid = res_r.target_valid;
  assign out_target_floor = res_r.target_floor;

endmodule
